// ===== design/lfbr_pkg.sv =====
package lfbr_pkg;

    // Default buffer depth and register reset values
    localparam int unsigned FRAME_BYTES_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd2500;
    localparam logic [7:0]  FLUSH_RESET     = 8'd127;
    localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;
    localparam int unsigned STRICT_PREFIX   = 3;
    localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

    // Configuration port geometry
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register indexes (paddr[2])
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_FLUSH   = 1'b1;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic append;
        logic clear;
        logic idle_zero;
        logic idle_tick;
        logic idx_next;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_newline;
        logic is_flush;
        logic is_full;
        logic is_early_bad;
        logic timeout_hit;
        logic is_last_idx;
    } t_dp_stat;

    function automatic logic is_alnum(input logic [7:0] b);
        is_alnum = ((b >= 8'h30) && (b <= 8'h39)) ||
                   ((b >= 8'h41) && (b <= 8'h5A)) ||
                   ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

// ===== design/lfbr_ram.sv =====
module lfbr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lfbr_dp.sv =====
module lfbr_dp #(
    parameter int unsigned FRAME_BYTES = lfbr_pkg::FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfbr_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_timeout_ms,
    input  logic [7:0]        i_flush_byte,
    output lfbr_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_frame_byte,
    output logic [3:0]        o_byte_index,
    output logic [4:0]        o_frame_length,
    output logic              o_last
);

    import lfbr_pkg::*;

    localparam int unsigned IDX_W  = $clog2(FRAME_BYTES);
    localparam int unsigned FILL_W = $clog2(FRAME_BYTES + 1);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [15:0]       r_idle, n_idle;
    logic [15:0]       idle_inc;
    logic [7:0]        ram_q;

    // Frame buffer: written at the fill position, read at the burst index
    lfbr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    // Saturating idle time after one more tick
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;

    // Classify the incoming byte and the timer
    always_comb begin
        o_stat.is_newline   = (i_rx_byte == NEWLINE_BYTE);
        o_stat.is_flush     = (i_rx_byte == i_flush_byte);
        o_stat.is_full      = (r_fill >= FILL_W'(FRAME_BYTES));
        o_stat.is_early_bad = (r_fill < FILL_W'(STRICT_PREFIX)) && !is_alnum(i_rx_byte);
        o_stat.timeout_hit  = (r_fill != '0) && (idle_inc > i_timeout_ms);
        o_stat.is_last_idx  = (r_idx == IDX_W'(FRAME_BYTES - 1));
    end

    // Next fill count, burst index and idle time
    always_comb begin
        n_fill = r_fill;
        n_idx  = r_idx;
        n_idle = r_idle;
        if (i_cmd.clear) begin
            n_fill = '0;
            n_idx  = '0;
        end else if (i_cmd.append) begin
            n_fill = r_fill + FILL_W'(1);
        end
        if (i_cmd.idx_next) begin
            n_idx = r_idx + IDX_W'(1);
        end
        if (i_cmd.idle_zero) begin
            n_idle = '0;
        end else if (i_cmd.idle_tick) begin
            n_idle = idle_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
            r_idle <= '0;
        end else begin
            r_fill <= n_fill;
            r_idx  <= n_idx;
            r_idle <= n_idle;
        end
    end

    // Drive the result; positions beyond the fill read as zero
    assign o_frame_byte   = (FILL_W'(r_idx) < r_fill) ? ram_q : 8'd0;
    assign o_byte_index   = 4'(r_idx);
    assign o_frame_length = 5'(r_fill);
    assign o_last         = o_stat.is_last_idx;

endmodule

// ===== design/lfbr_ctrl.sv =====
module lfbr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_kind,
    input  logic               i_out_ready,
    input  lfbr_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output lfbr_pkg::t_dp_cmd  o_cmd
);

    import lfbr_pkg::*;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_kind == KIND_BYTE) && i_stat.is_newline) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (i_out_ready) begin
                    n_state = i_stat.is_last_idx ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshakes and datapath commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_kind == KIND_TICK) begin
                        o_cmd.idle_tick = 1'b1;
                        o_cmd.clear     = i_stat.timeout_hit;
                    end else begin
                        o_cmd.idle_zero = 1'b1;
                        if (!i_stat.is_newline) begin
                            if (i_stat.is_flush || i_stat.is_full || i_stat.is_early_bad) begin
                                o_cmd.clear = 1'b1;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_FETCH: begin
                // read issued at the burst index; data lands next cycle
            end
            ST_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.is_last_idx) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.idx_next = 1'b1;
                    end
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/line_framed_byte_receiver.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_kind, i_rx_byte
// result    out        o_out_valid / i_out_ready o_frame_byte, o_byte_index,
//                                                o_frame_length, o_last
// config    in         APB psel/penable/pwrite   paddr, pwdata -> prdata
//
// A byte or tick item is taken whenever the receiver is idle; the next item may follow at once.
// A newline starts a readout of FRAME_BYTES results, each a buffer read, then show,
// since the buffer RAM has a single registered read port.
// No item is taken during the readout; a stalled result holds until taken.
// Reset is synchronous and active low; it empties the frame and restores
// timeout 2500 and flush byte 127. The buffer needs no clearing pass.
module line_framed_byte_receiver #(
    parameter int unsigned FRAME_BYTES = lfbr_pkg::FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_frame_byte,
    output logic [3:0]                  o_byte_index,
    output logic [4:0]                  o_frame_length,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfbr_pkg::APB_AW-1:0] paddr,
    input  logic [lfbr_pkg::APB_DW-1:0] pwdata,
    output logic [lfbr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    import lfbr_pkg::*;

    logic [15:0] r_timeout_ms;
    logic [7:0]  r_flush_byte;
    logic        cfg_wr;
    t_dp_cmd     cmd;
    t_dp_stat    stat;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
            r_flush_byte <= FLUSH_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TIMEOUT: r_timeout_ms <= pwdata[15:0];
                REG_FLUSH:   r_flush_byte <= pwdata[7:0];
                default:     r_timeout_ms <= r_timeout_ms;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TIMEOUT: prdata = APB_DW'(r_timeout_ms);
            REG_FLUSH:   prdata = APB_DW'(r_flush_byte);
            default:     prdata = '0;
        endcase
    end

    lfbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lfbr_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rx_byte      (i_rx_byte),
        .i_timeout_ms   (r_timeout_ms),
        .i_flush_byte   (r_flush_byte),
        .o_stat         (stat),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

    // Input and result sides never open together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready during readout");

    // A newline brings the first result after the fetch state
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_kind == KIND_BYTE) && (i_rx_byte == NEWLINE_BYTE))
        |=> ##1 o_out_valid)
        else $error("readout did not start");

    // The frame is empty once its last byte is taken
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> (o_frame_length == 5'd0))
        else $error("frame not cleared after readout");

    // Append never runs beyond the buffer
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.append |-> !stat.is_full)
        else $error("append into full buffer");

endmodule
